@@ sv/deq_pkg.sv @@
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = $clog2(2 * DEPTH + 1);

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef logic [2:0] req_t;
  localparam req_t REQ_PUSH_FRONT = 3'd0;
  localparam req_t REQ_PUSH_BACK  = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_REVERSE    = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITEBACK
  } state_t;

  typedef struct packed {
    logic exec;
    logic capture;
  } cmd_t;

endpackage

@@ sv/double_ended_queue.sv @@
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_ready  | in_req_type, in_value
// out      | out_valid / out_ready| out_status, out_front_value, out_back_value,
//          |                      | out_is_empty, out_entry_count
//
// Each request runs in steps: pointer update and ring write, registered read of
// the front and back slots from the two-read ring RAM, then load of the result.
// Reset (rst_n low, synchronous) clears head, count, direction flag and the
// output valid; the ring contents are not cleared.
// A result waiting on out_ready holds back the next result load, and with it the
// input; a new request is taken while the previous result still waits.
module double_ended_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_front_value,
  output logic [31:0] out_back_value,
  output logic        out_is_empty,
  output logic [4:0]  out_entry_count
);

  deq_pkg::cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  deq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count)
  );

  // a transfer in keeps the input closed for the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a request is in flight");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_front_value == 32'd0 && out_back_value == 32'd0)
    else $error("empty result carries non-zero words");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == 5'd0)))
    else $error("empty flag disagrees with entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_entry_count) <= 32'(deq_pkg::DEPTH))
    else $error("entry count beyond depth");

endmodule

@@ sv/deq_ram.sv @@
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

@@ sv/deq_ctrl.sv @@
module deq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output deq_pkg::cmd_t cmd
);

  deq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.exec      = 1'b0;
    cmd.capture   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      deq_pkg::S_IDLE: begin
        // input stays closed while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.exec  = 1'b1;
          state_nxt = deq_pkg::S_READ;
        end
      end
      deq_pkg::S_READ: begin
        state_nxt = deq_pkg::S_WRITEBACK;
      end
      deq_pkg::S_WRITEBACK: begin
        // output register must be free (or freeing) before loading
        if (!out_valid_r || out_ready) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = deq_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/deq_dp.sv @@
module deq_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  deq_pkg::cmd_t cmd,
  input  logic [2:0]    in_req_type,
  input  logic [31:0]   in_value,
  output logic [1:0]    out_status,
  output logic [31:0]   out_front_value,
  output logic [31:0]   out_back_value,
  output logic          out_is_empty,
  output logic [4:0]    out_entry_count
);

  deq_pkg::idx_t    head_r, head_nxt;
  deq_pkg::cnt_t    count_r, count_nxt;
  logic             rev_r, rev_nxt;
  deq_pkg::status_t status_r, status_nxt;

  logic [1:0]  res_status_r;
  logic [31:0] res_front_r;
  logic [31:0] res_back_r;
  logic        res_empty_r;
  logic [4:0]  res_count_r;

  logic            we;
  deq_pkg::idx_t   waddr;
  deq_pkg::word_t  wdata;
  deq_pkg::idx_t   raddr_a, raddr_b;
  deq_pkg::word_t  rdata_a, rdata_b;
  deq_pkg::word_t  front_word, back_word;
  logic            phys_front;
  logic            full, empty;

  // (a + b) mod DEPTH, with a < DEPTH and b <= DEPTH
  function automatic deq_pkg::idx_t wrap_add(deq_pkg::idx_t a, deq_pkg::cnt_t b);
    logic [deq_pkg::SUM_W-1:0] sum;
    sum = deq_pkg::SUM_W'(a) + deq_pkg::SUM_W'(b);
    if (sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH)) begin
      sum = sum - deq_pkg::SUM_W'(deq_pkg::DEPTH);
    end
    return deq_pkg::IDX_W'(sum);
  endfunction

  assign full  = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty = (count_r == '0);
  // does the request act on the physical head of the ring?
  assign phys_front = ((in_req_type == deq_pkg::REQ_PUSH_FRONT) ||
                       (in_req_type == deq_pkg::REQ_POP_FRONT)) != rev_r;
  assign wdata = deq_pkg::DATA_WIDTH'(in_value);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    status_nxt = deq_pkg::ST_DONE;
    we         = 1'b0;
    waddr      = head_r;
    case (in_req_type)
      deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          status_nxt = deq_pkg::ST_FULL;
        end else if (phys_front) begin
          head_nxt  = (head_r == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1) : head_r - 1'b1;
          waddr     = head_nxt;
          we        = cmd.exec;
          count_nxt = count_r + 1'b1;
        end else begin
          waddr     = wrap_add(head_r, count_r);
          we        = cmd.exec;
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
        if (empty) begin
          status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          if (phys_front) begin
            head_nxt = wrap_add(head_r, deq_pkg::CNT_W'(1));
          end
          count_nxt = count_r - 1'b1;
        end
      end
      deq_pkg::REQ_REVERSE: begin
        if (empty) begin
          status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          rev_nxt = !rev_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
  end

  // pointers are settled by the time the read is issued
  assign raddr_a = head_r;
  assign raddr_b = empty ? head_r : wrap_add(head_r, count_r - 1'b1);

  deq_ram #(
    .WIDTH (deq_pkg::DATA_WIDTH),
    .DEPTH (deq_pkg::DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    if (empty) begin
      front_word = '0;
      back_word  = '0;
    end else begin
      front_word = rev_r ? rdata_b : rdata_a;
      back_word  = rev_r ? rdata_a : rdata_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status_r <= status_r;
      res_front_r  <= 32'(front_word);
      res_back_r   <= 32'(back_word);
      res_empty_r  <= empty;
      res_count_r  <= 5'(count_r);
    end
  end

  assign out_status      = res_status_r;
  assign out_front_value = res_front_r;
  assign out_back_value  = res_back_r;
  assign out_is_empty    = res_empty_r;
  assign out_entry_count = res_count_r;

endmodule

@@ tb/tb_double_ended_queue.sv @@
module tb_double_ended_queue;

  // request codes the block must treat as no-ops
  localparam deq_pkg::req_t REQ_UNUSED_FIRST = 3'd5;
  localparam deq_pkg::req_t REQ_UNUSED_LAST  = 3'd7;

  localparam int HOLD_CYCLES = 120;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    deq_pkg::status_t status;
    deq_pkg::word_t   front_word;
    deq_pkg::word_t   back_word;
    logic             empty;
    deq_pkg::cnt_t    fill;
  } deq_view_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic [2:0]  in_req_type = deq_pkg::REQ_PUSH_FRONT;
  logic [31:0] in_value    = '0;
  logic        out_ready   = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_front_value;
  logic [31:0] out_back_value;
  logic        out_is_empty;
  logic [4:0]  out_entry_count;

  double_ended_queue uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // shadow deque state
  deq_pkg::word_t shadow_ring [deq_pkg::DEPTH];
  deq_pkg::idx_t  shadow_head = '0;
  int             shadow_count = 0;
  bit             shadow_reversed = 1'b0;
  deq_view_t      pending_views [$];

  logic hold_req = 1'b0;
  bit   no_gaps  = 1'b0;
  int   errors = 0;
  int   n_requests = 0;
  int   n_reversals = 0;
  int   n_checked = 0;
  int   n_refused_full = 0;
  int   n_refused_empty = 0;

  function automatic deq_view_t apply_request(deq_pkg::req_t kind, deq_pkg::word_t word);
    deq_view_t      view;
    deq_pkg::word_t first_w;
    deq_pkg::word_t last_w;
    view = '0;
    view.status = deq_pkg::ST_DONE;
    first_w = '0;
    last_w = '0;
    case (kind)
      deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
        if (shadow_count >= deq_pkg::DEPTH) begin
          view.status = deq_pkg::ST_FULL;
        end else if ((kind == deq_pkg::REQ_PUSH_FRONT) != shadow_reversed) begin
          shadow_head = (shadow_head == 0) ? deq_pkg::idx_t'(deq_pkg::DEPTH - 1)
                                           : shadow_head - 1'b1;
          shadow_ring[shadow_head] = word;
          shadow_count++;
        end else begin
          shadow_ring[deq_pkg::idx_t'((int'(shadow_head) + shadow_count) % deq_pkg::DEPTH)]
            = word;
          shadow_count++;
        end
      end
      deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
        if (shadow_count == 0) begin
          view.status = deq_pkg::ST_EMPTY;
        end else if ((kind == deq_pkg::REQ_POP_FRONT) != shadow_reversed) begin
          shadow_head = deq_pkg::idx_t'((int'(shadow_head) + 1) % deq_pkg::DEPTH);
          shadow_count--;
        end else begin
          shadow_count--;
        end
      end
      deq_pkg::REQ_REVERSE: begin
        if (shadow_count == 0) view.status = deq_pkg::ST_EMPTY;
        else shadow_reversed = !shadow_reversed;
      end
      default: ;
    endcase
    if (shadow_count != 0) begin
      first_w = shadow_ring[shadow_head];
      last_w  = shadow_ring[deq_pkg::idx_t'((int'(shadow_head) + shadow_count - 1)
                                            % deq_pkg::DEPTH)];
    end
    view.front_word = shadow_reversed ? last_w : first_w;
    view.back_word  = shadow_reversed ? first_w : last_w;
    view.empty      = (shadow_count == 0);
    view.fill       = deq_pkg::cnt_t'(shadow_count);
    return view;
  endfunction

  // mostly back-to-back, some short gaps, the odd long one
  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic deq_pkg::word_t pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return deq_pkg::word_t'($urandom);
    endcase
  endfunction

  function automatic deq_pkg::req_t pick_request(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3)
      return deq_pkg::req_t'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
    if (roll < 9) return deq_pkg::REQ_REVERSE;
    if (roll < 9 + push_pct * 91 / 100)
      return $urandom_range(0, 1) ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT;
    return $urandom_range(0, 1) ? deq_pkg::REQ_POP_BACK : deq_pkg::REQ_POP_FRONT;
  endfunction

  task automatic issue_request(deq_pkg::req_t kind, deq_pkg::word_t word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_value    <= word;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_views.push_back(apply_request(kind, word));
    n_requests++;
    if (kind == deq_pkg::REQ_REVERSE) n_reversals++;
  endtask

  task automatic test_empty_requests();
    issue_request(deq_pkg::REQ_POP_FRONT, '1);
    issue_request(deq_pkg::REQ_POP_BACK, '0);
    issue_request(deq_pkg::REQ_REVERSE, pick_word());
    issue_request(REQ_UNUSED_FIRST, pick_word());
    issue_request(REQ_UNUSED_LAST, pick_word());
  endtask

  task automatic test_fill_and_overflow();
    deq_pkg::word_t word;
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      word = (i == 0) ? '0 : (i == 1) ? '1 : deq_pkg::word_t'($urandom);
      issue_request((i % 2) ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT, word);
    end
    issue_request(deq_pkg::REQ_PUSH_FRONT, pick_word());
    issue_request(deq_pkg::REQ_PUSH_BACK, pick_word());
    issue_request(deq_pkg::REQ_REVERSE, pick_word());
    issue_request(deq_pkg::REQ_POP_FRONT, pick_word());
    issue_request(deq_pkg::REQ_POP_BACK, pick_word());
  endtask

  task automatic test_random_traffic(int n_items, int push_pct);
    for (int i = 0; i < n_items; i++)
      issue_request(pick_request(push_pct), pick_word());
  endtask

  task automatic test_burst_traffic(int n_items);
    no_gaps = 1'b1;
    test_random_traffic(n_items, 50);
    no_gaps = 1'b0;
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_back_pressure();
    no_gaps = 1'b1;
    hold_req <= 1'b1;
    test_random_traffic(60, 60);
    no_gaps = 1'b0;
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  initial begin : result_sink
    int        stall_left;
    deq_view_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_views.size() == 0) begin
          $error("result transfer with no request outstanding");
          errors++;
        end else begin
          want = pending_views.pop_front();
          n_checked++;
          if (want.status == deq_pkg::ST_FULL) n_refused_full++;
          if (want.status == deq_pkg::ST_EMPTY) n_refused_empty++;
          compare_field("status", 32'(want.status), 32'(out_status));
          compare_field("front_value", want.front_word, out_front_value);
          compare_field("back_value", want.back_word, out_back_value);
          compare_field("is_empty", 32'(want.empty), 32'(out_is_empty));
          compare_field("entry_count", 32'(want.fill), 32'(out_entry_count));
        end
      end
      if (hold_req) begin
        hold_req <= 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !no_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      out_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("no transfer for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending_views.size());
    $display("tb_double_ended_queue failed");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_requests();
    test_fill_and_overflow();
    test_random_traffic(250, 70);
    test_random_traffic(250, 30);
    test_burst_traffic(150);
    test_back_pressure();
    test_random_traffic(300, 50);
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d requests sent, %0d results checked", n_requests, n_checked);
    $display("refusals: %0d on full, %0d on empty; %0d reverse requests",
             n_refused_full, n_refused_empty, n_reversals);
    if (errors == 0) $display("tb_double_ended_queue passed");
    else $display("tb_double_ended_queue failed");
    $finish;
  end

endmodule
